// ===== src/weighted_hit_centroid_assert.svh =====
// Assertion macros shared by the centroid block.
// All checks are clocked on i_clk and are held off while i_rst_n is low.
`ifndef WEIGHTED_HIT_CENTROID_ASSERT_SVH
`define WEIGHTED_HIT_CENTROID_ASSERT_SVH

// A condition that must hold at every clock edge.
`define WHC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// A consequence that must hold in the same cycle as its cause.
`define WHC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A consequence that must hold in the cycle after its cause.
`define WHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/whc_pkg.sv =====
package whc_pkg;

    // Field widths of the hit and result items.
    localparam int POS_W   = 16;
    localparam int EN_W    = 24;
    localparam int PROD_W  = POS_W + EN_W;
    localparam int OUT_W   = 24;
    localparam int FRAC_W  = 8;
    localparam int HIT_W   = 9;
    localparam int STAT_W  = 2;
    localparam int MODE_W  = 2;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Weight mode register codes.
    localparam logic [MODE_W-1:0] MODE_UNIT   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ENERGY = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MAX    = 2'd2;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERO_W   = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;

    // Accumulate operation chosen for a hit by the front.
    typedef enum logic [1:0] {
        OP_UNIT   = 2'd0,
        OP_ENERGY = 2'd1,
        OP_MAX    = 2'd2
    } t_op;

    // One classified hit as it travels through the queue.
    typedef struct packed {
        t_op                      op;
        logic                     last;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic [EN_W-1:0]          e;
        logic signed [PROD_W-1:0] px;
        logic signed [PROD_W-1:0] py;
    } t_hit;

endpackage

// ===== src/whc_front.sv =====
module whc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [whc_pkg::MODE_W-1:0]          i_cfg_weight_mode,
    input  logic                                i_hit_valid,
    output logic                                o_hit_ready,
    input  logic signed [whc_pkg::POS_W-1:0]    i_x_position,
    input  logic signed [whc_pkg::POS_W-1:0]    i_y_position,
    input  logic [whc_pkg::EN_W-1:0]            i_energy,
    input  logic                                i_last_hit,
    output logic                                o_push_valid,
    input  logic                                i_push_ready,
    output whc_pkg::t_hit                       o_push_hit
);

    logic [whc_pkg::MODE_W-1:0] r_mode;
    logic                       r_valid;
    whc_pkg::t_hit              r_hit;
    logic                       n_valid;
    whc_pkg::t_hit              n_hit;
    logic                       hit_xfer;
    whc_pkg::t_op               op_sel;

    // The mode register takes every write.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= whc_pkg::MODE_UNIT;
        end else if (i_cfg_valid) begin
            r_mode <= i_cfg_weight_mode;
        end
    end

    // Pick the accumulate operation from the mode in force for this hit.
    always_comb begin
        unique case (r_mode)
            whc_pkg::MODE_ENERGY: op_sel = whc_pkg::OP_ENERGY;
            whc_pkg::MODE_MAX:    op_sel = whc_pkg::OP_MAX;
            default:              op_sel = whc_pkg::OP_UNIT;
        endcase
    end

    // The stage register frees up whenever the queue takes its content.
    assign o_hit_ready = !r_valid || i_push_ready;
    assign hit_xfer    = i_hit_valid && o_hit_ready;

    // Classify the hit and form both weighted products.
    always_comb begin
        n_valid = r_valid;
        n_hit   = r_hit;
        if (r_valid && i_push_ready) begin
            n_valid = 1'b0;
        end
        if (hit_xfer) begin
            n_valid  = 1'b1;
            n_hit.op = op_sel;
            n_hit.last = i_last_hit;
            n_hit.x  = i_x_position;
            n_hit.y  = i_y_position;
            n_hit.e  = i_energy;
            n_hit.px = i_x_position * $signed({1'b0, i_energy});
            n_hit.py = i_y_position * $signed({1'b0, i_energy});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit <= n_hit;
    end

    assign o_push_valid = r_valid;
    assign o_push_hit   = r_hit;

endmodule

// ===== src/whc_fifo.sv =====
`include "weighted_hit_centroid_assert.svh"

module whc_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  whc_pkg::t_hit i_push_hit,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output whc_pkg::t_hit o_pop_hit
);

    localparam int DEPTH = whc_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    whc_pkg::t_hit    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = r_count != CNT_W'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign o_pop_hit    = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    // Pointers wrap at the queue depth.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
            end
            if (push && !pop) begin
                r_count <= CNT_W'(r_count + 1'b1);
            end else if (pop && !push) begin
                r_count <= CNT_W'(r_count - 1'b1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_hit;
        end
    end

    `WHC_ASSERT_ALWAYS(a_fifo_bound, r_count <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

// ===== src/whc_div.sv =====
`include "weighted_hit_centroid_assert.svh"

module whc_div #(
    parameter int CNT_W = 9
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_start,
    input  logic signed [whc_pkg::PROD_W+CNT_W-1:0] i_sum_x,
    input  logic signed [whc_pkg::PROD_W+CNT_W-1:0] i_sum_y,
    input  logic [whc_pkg::EN_W+CNT_W-1:0]          i_wt,
    output logic                                    o_done,
    output logic signed [whc_pkg::OUT_W-1:0]        o_x,
    output logic signed [whc_pkg::OUT_W-1:0]        o_y
);

    localparam int SUM_W  = whc_pkg::PROD_W + CNT_W;
    localparam int WT_W   = whc_pkg::EN_W + CNT_W;
    localparam int OUT_W  = whc_pkg::OUT_W;
    localparam int FRAC_W = whc_pkg::FRAC_W;
    localparam int LO_W   = OUT_W - FRAC_W;
    localparam int STEP_W = $clog2(OUT_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [WT_W-1:0]   r_div;
    logic [WT_W-1:0]   r_rem_x;
    logic [WT_W-1:0]   r_rem_y;
    logic [OUT_W-1:0]  r_q_x;
    logic [OUT_W-1:0]  r_q_y;
    logic              r_neg_x;
    logic              r_neg_y;
    logic              r_zero;
    logic [SUM_W-1:0]  mag_x;
    logic [SUM_W-1:0]  mag_y;
    logic [WT_W+OUT_W-1:0] step_x;
    logic [WT_W+OUT_W-1:0] step_y;

    // One restoring step: the next dividend bit comes from the top of q,
    // and the quotient bit shifts in at its bottom.
    function automatic logic [WT_W+OUT_W-1:0] div_step(
        input logic [WT_W-1:0]  rem,
        input logic [OUT_W-1:0] q,
        input logic [WT_W-1:0]  dv
    );
        logic [WT_W:0] trial;
        logic [WT_W:0] diff;
        trial = {rem, q[OUT_W-1]};
        diff  = trial - {1'b0, dv};
        if (trial >= {1'b0, dv}) begin
            return {diff[WT_W-1:0], q[OUT_W-2:0], 1'b1};
        end
        return {trial[WT_W-1:0], q[OUT_W-2:0], 1'b0};
    endfunction

    // Divide magnitudes; the sign is put back at the end.
    assign mag_x  = i_sum_x[SUM_W-1] ? SUM_W'(-i_sum_x) : SUM_W'(i_sum_x);
    assign mag_y  = i_sum_y[SUM_W-1] ? SUM_W'(-i_sum_y) : SUM_W'(i_sum_y);
    assign step_x = div_step(r_rem_x, r_q_x, r_div);
    assign step_y = div_step(r_rem_y, r_q_y, r_div);

    // Step control. The quotient of a mean fits in OUT_W bits, so the part of
    // the scaled sum above those bits is already below the divisor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= STEP_W'(r_step + 1'b1);
                if (r_step == STEP_W'(OUT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand load and shift datapath.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_div   <= i_wt;
            r_zero  <= i_wt == '0;
            r_neg_x <= i_sum_x[SUM_W-1];
            r_neg_y <= i_sum_y[SUM_W-1];
            r_rem_x <= mag_x[SUM_W-1:LO_W];
            r_rem_y <= mag_y[SUM_W-1:LO_W];
            r_q_x   <= {mag_x[LO_W-1:0], FRAC_W'(0)};
            r_q_y   <= {mag_y[LO_W-1:0], FRAC_W'(0)};
        end else if (r_busy) begin
            r_rem_x <= step_x[WT_W+OUT_W-1:OUT_W];
            r_q_x   <= step_x[OUT_W-1:0];
            r_rem_y <= step_y[WT_W+OUT_W-1:OUT_W];
            r_q_y   <= step_y[OUT_W-1:0];
        end
    end

    // Signed results; a zero weight sum gives zero.
    assign o_done = r_done;
    assign o_x    = r_zero ? '0 : (r_neg_x ? OUT_W'(-r_q_x) : r_q_x);
    assign o_y    = r_zero ? '0 : (r_neg_y ? OUT_W'(-r_q_y) : r_q_y);

    `WHC_ASSERT_IMPLY(a_div_start_idle, i_start, !r_busy, "divide started while busy")
    `WHC_ASSERT_NEXT(a_div_done_pulse, r_done, !r_done && !r_busy, "done is not a single pulse")

endmodule

// ===== src/whc_back.sv =====
`include "weighted_hit_centroid_assert.svh"

module whc_back #(
    parameter int MAX_HITS = 256,
    parameter int CNT_W    = 9
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_pop_valid,
    output logic                                    o_pop_ready,
    input  whc_pkg::t_hit                           i_pop_hit,
    output logic                                    o_div_start,
    output logic signed [whc_pkg::PROD_W+CNT_W-1:0] o_div_sum_x,
    output logic signed [whc_pkg::PROD_W+CNT_W-1:0] o_div_sum_y,
    output logic [whc_pkg::EN_W+CNT_W-1:0]          o_div_wt,
    input  logic                                    i_div_done,
    input  logic signed [whc_pkg::OUT_W-1:0]        i_div_x,
    input  logic signed [whc_pkg::OUT_W-1:0]        i_div_y,
    output logic                                    o_res_valid,
    input  logic                                    i_res_ready,
    output logic signed [whc_pkg::OUT_W-1:0]        o_x_centroid,
    output logic signed [whc_pkg::OUT_W-1:0]        o_y_centroid,
    output logic [whc_pkg::HIT_W-1:0]               o_hit_total,
    output logic [whc_pkg::STAT_W-1:0]              o_status
);

    localparam int SUM_W = whc_pkg::PROD_W + CNT_W;
    localparam int WT_W  = whc_pkg::EN_W + CNT_W;

    typedef enum logic [1:0] {
        S_ACC = 2'b01,
        S_DIV = 2'b10
    } t_back_state;

    t_back_state                 r_state, n_state;
    logic signed [SUM_W-1:0]     r_sum_x, n_sum_x, a_sum_x;
    logic signed [SUM_W-1:0]     r_sum_y, n_sum_y, a_sum_y;
    logic [WT_W-1:0]             r_wt, n_wt, a_wt;
    logic [CNT_W-1:0]            r_hits, n_hits, a_hits;
    logic [whc_pkg::EN_W-1:0]    r_max, n_max, a_max;
    logic                        r_ovf, n_ovf, a_ovf;
    logic [CNT_W-1:0]            r_pend_total, n_pend_total;
    logic [whc_pkg::STAT_W-1:0]  r_pend_status, n_pend_status;
    logic                        r_out_valid, n_out_valid;
    logic signed [whc_pkg::OUT_W-1:0] r_x, n_x, r_y, n_y;
    logic                        full;
    logic                        first;
    logic                        gt;
    logic                        eq;
    logic                        pop;
    logic [31:0]                 total_wide;

    // Take a hit unless dividing, or unless it ends a cluster while the
    // previous result still waits.
    assign pop = (r_state == S_ACC) && i_pop_valid && (!i_pop_hit.last || !r_out_valid);
    assign o_pop_ready = pop;

    assign full  = r_hits >= CNT_W'(MAX_HITS);
    assign first = r_hits == '0;
    assign gt    = first || (i_pop_hit.e > r_max);
    assign eq    = i_pop_hit.e == r_max;

    // Cluster state after applying the hit at the head of the queue.
    always_comb begin
        a_sum_x = r_sum_x;
        a_sum_y = r_sum_y;
        a_wt    = r_wt;
        a_hits  = r_hits;
        a_max   = r_max;
        a_ovf   = r_ovf;
        if (full) begin
            a_ovf = 1'b1;
        end else begin
            unique case (i_pop_hit.op)
                whc_pkg::OP_ENERGY: begin
                    a_sum_x = r_sum_x + SUM_W'(i_pop_hit.px);
                    a_sum_y = r_sum_y + SUM_W'(i_pop_hit.py);
                    a_wt    = r_wt + WT_W'(i_pop_hit.e);
                end
                whc_pkg::OP_MAX: begin
                    if (gt) begin
                        a_sum_x = SUM_W'(i_pop_hit.x);
                        a_sum_y = SUM_W'(i_pop_hit.y);
                        a_wt    = WT_W'(1);
                    end else if (eq) begin
                        a_sum_x = r_sum_x + SUM_W'(i_pop_hit.x);
                        a_sum_y = r_sum_y + SUM_W'(i_pop_hit.y);
                        a_wt    = WT_W'(r_wt + 1'b1);
                    end
                end
                default: begin
                    a_sum_x = r_sum_x + SUM_W'(i_pop_hit.x);
                    a_sum_y = r_sum_y + SUM_W'(i_pop_hit.y);
                    a_wt    = WT_W'(r_wt + 1'b1);
                end
            endcase
            if (gt) begin
                a_max = i_pop_hit.e;
            end
            a_hits = CNT_W'(r_hits + 1'b1);
        end
    end

    assign o_div_sum_x = a_sum_x;
    assign o_div_sum_y = a_sum_y;
    assign o_div_wt    = a_wt;

    // Sequencing of accumulation, the final divide and the result register.
    always_comb begin
        n_state       = r_state;
        n_sum_x       = r_sum_x;
        n_sum_y       = r_sum_y;
        n_wt          = r_wt;
        n_hits        = r_hits;
        n_max         = r_max;
        n_ovf         = r_ovf;
        n_pend_total  = r_pend_total;
        n_pend_status = r_pend_status;
        n_out_valid   = r_out_valid;
        n_x           = r_x;
        n_y           = r_y;
        o_div_start   = 1'b0;
        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_ACC: begin
                if (pop) begin
                    n_sum_x = a_sum_x;
                    n_sum_y = a_sum_y;
                    n_wt    = a_wt;
                    n_hits  = a_hits;
                    n_max   = a_max;
                    n_ovf   = a_ovf;
                    if (i_pop_hit.last) begin
                        o_div_start  = 1'b1;
                        n_pend_total = a_hits;
                        priority if (a_ovf) begin
                            n_pend_status = whc_pkg::ST_OVERFLOW;
                        end else if (a_wt == '0) begin
                            n_pend_status = whc_pkg::ST_ZERO_W;
                        end else begin
                            n_pend_status = whc_pkg::ST_OK;
                        end
                        n_sum_x = '0;
                        n_sum_y = '0;
                        n_wt    = '0;
                        n_hits  = '0;
                        n_max   = '0;
                        n_ovf   = 1'b0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (i_div_done) begin
                    n_x         = i_div_x;
                    n_y         = i_div_y;
                    n_out_valid = 1'b1;
                    n_state     = S_ACC;
                end
            end
            default: begin
                n_state = S_ACC;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_ACC;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_wt        <= '0;
            r_hits      <= '0;
            r_max       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum_x     <= n_sum_x;
            r_sum_y     <= n_sum_y;
            r_wt        <= n_wt;
            r_hits      <= n_hits;
            r_max       <= n_max;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_total  <= n_pend_total;
        r_pend_status <= n_pend_status;
        r_x           <= n_x;
        r_y           <= n_y;
    end

    // The reported count keeps its low bits only.
    assign total_wide   = 32'(r_pend_total);
    assign o_res_valid  = r_out_valid;
    assign o_x_centroid = r_x;
    assign o_y_centroid = r_y;
    assign o_hit_total  = total_wide[whc_pkg::HIT_W-1:0];
    assign o_status     = r_pend_status;

    `WHC_ASSERT_IMPLY(a_back_no_overwrite, i_div_done, !r_out_valid, "result overwritten")

endmodule

// ===== src/weighted_hit_centroid.sv =====
// Weighted hit centroid.
// Hits of one cluster arrive on the hit channel (valid/ready), one transfer
// per hit, the final hit flagged by i_last_hit. The block answers each
// cluster with one transfer on the result channel: the mean x and y as
// signed Q16.8 truncated toward zero, the hit count and a status code.
// The weight mode register is written through the configuration channel,
// which is always ready; write it only between clusters.
// Throughput: one hit per cycle while the queue has room. The final hit of
// a cluster holds the accumulator while the two-lane restoring divider runs
// one quotient bit per cycle over 24 bits; a four-entry queue behind the
// input stage keeps taking hits meanwhile until it fills.
// The final hit passes the input stage register and the queue; then the
// accumulator starts the divider, and its quotients load the result register.
// The result sits in an output register; when the receiver stalls, hits
// keep accumulating, and only the next final hit waits for that register.
// Synchronous reset clears the sums, the queue and the result valid and
// sets the mode to unit weights.
module weighted_hit_centroid #(
    parameter int MAX_HITS = 256
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [whc_pkg::MODE_W-1:0]       i_cfg_weight_mode,
    input  logic                             i_hit_valid,
    output logic                             o_hit_ready,
    input  logic signed [whc_pkg::POS_W-1:0] i_x_position,
    input  logic signed [whc_pkg::POS_W-1:0] i_y_position,
    input  logic [whc_pkg::EN_W-1:0]         i_energy,
    input  logic                             i_last_hit,
    output logic                             o_res_valid,
    input  logic                             i_res_ready,
    output logic signed [whc_pkg::OUT_W-1:0] o_x_centroid,
    output logic signed [whc_pkg::OUT_W-1:0] o_y_centroid,
    output logic [whc_pkg::HIT_W-1:0]        o_hit_total,
    output logic [whc_pkg::STAT_W-1:0]       o_status
);

    localparam int CNT_W = $clog2(MAX_HITS + 1);
    localparam int SUM_W = whc_pkg::PROD_W + CNT_W;
    localparam int WT_W  = whc_pkg::EN_W + CNT_W;

    logic                             push_valid;
    logic                             push_ready;
    whc_pkg::t_hit                    push_hit;
    logic                             pop_valid;
    logic                             pop_ready;
    whc_pkg::t_hit                    pop_hit;
    logic                             div_start;
    logic signed [SUM_W-1:0]          div_sum_x;
    logic signed [SUM_W-1:0]          div_sum_y;
    logic [WT_W-1:0]                  div_wt;
    logic                             div_done;
    logic signed [whc_pkg::OUT_W-1:0] div_x;
    logic signed [whc_pkg::OUT_W-1:0] div_y;

    // Input stage: mode register, hit classification and products.
    whc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_weight_mode (i_cfg_weight_mode),
        .i_hit_valid       (i_hit_valid),
        .o_hit_ready       (o_hit_ready),
        .i_x_position      (i_x_position),
        .i_y_position      (i_y_position),
        .i_energy          (i_energy),
        .i_last_hit        (i_last_hit),
        .o_push_valid      (push_valid),
        .i_push_ready      (push_ready),
        .o_push_hit        (push_hit)
    );

    // Queue between the input stage and the accumulator.
    whc_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_hit   (push_hit),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_hit    (pop_hit)
    );

    // Accumulator, end-of-cluster control and result register.
    whc_back #(
        .MAX_HITS (MAX_HITS),
        .CNT_W    (CNT_W)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pop_valid  (pop_valid),
        .o_pop_ready  (pop_ready),
        .i_pop_hit    (pop_hit),
        .o_div_start  (div_start),
        .o_div_sum_x  (div_sum_x),
        .o_div_sum_y  (div_sum_y),
        .o_div_wt     (div_wt),
        .i_div_done   (div_done),
        .i_div_x      (div_x),
        .i_div_y      (div_y),
        .o_res_valid  (o_res_valid),
        .i_res_ready  (i_res_ready),
        .o_x_centroid (o_x_centroid),
        .o_y_centroid (o_y_centroid),
        .o_hit_total  (o_hit_total),
        .o_status     (o_status)
    );

    // Bit-serial divider for both coordinates.
    whc_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_sum_x (div_sum_x),
        .i_sum_y (div_sum_y),
        .i_wt    (div_wt),
        .o_done  (div_done),
        .o_x     (div_x),
        .o_y     (div_y)
    );

endmodule
